FILE: rtl/cbm_pkg.sv
package cbm_pkg;

  // Cartridge size, in banks of the unit each window is counted in.
  localparam int unsigned PRG_BANKS_8K = 64;
  localparam int unsigned CHR_BANKS_1K = 256;

  // Request kinds.
  localparam logic [1:0] ACT_WRITE    = 2'd0;
  localparam logic [1:0] ACT_PRG_READ = 2'd1;
  localparam logic [1:0] ACT_CHR_READ = 2'd2;
  localparam logic [1:0] ACT_TICK     = 2'd3;

  // Write decode: the 8K region select (address bits 15:13).
  localparam logic [2:0] REGION_CONTROL = 3'b011;
  localparam logic [2:0] REGION_MIRROR  = 3'b100;
  localparam logic [2:0] REGION_SELECT  = 3'b101;
  localparam logic [2:0] REGION_LOAD    = 3'b110;
  localparam logic [2:0] REGION_IRQ     = 3'b111;

  localparam logic [15:0] ADDR_IRQ_ACK    = 16'hE002;
  localparam logic [15:0] ADDR_IRQ_RELOAD = 16'hE003;

  // The upper program window is fixed to the last two 8K banks.
  localparam logic [7:0] PRG_FIXED_BASE = 8'(PRG_BANKS_8K - 2);

  typedef logic [7:0] wrap_table_t [256];

  // Bank number modulo the ROM size, built as a table at elaboration.
  function automatic wrap_table_t make_wrap_table(input int unsigned banks);
    wrap_table_t tbl;
    int unsigned rem;
    rem = 0;
    for (int i = 0; i < 256; i++) begin
      tbl[i] = 8'(rem);
      rem = rem + 1;
      if (rem == banks) begin
        rem = 0;
      end
    end
    return tbl;
  endfunction

  localparam wrap_table_t PRG_WRAP = make_wrap_table(PRG_BANKS_8K);
  localparam wrap_table_t CHR_WRAP = make_wrap_table(CHR_BANKS_1K);

  // Mapper state seen by the translation logic.
  typedef struct packed {
    logic [7:0]      control;
    logic [7:0][7:0] banks;
  } cbm_state_t;

  // Status flags as they stand after the current request.
  typedef struct packed {
    logic mirror;
    logic irq;
  } cbm_flags_t;

endpackage

FILE: rtl/cbm_req_if.sv
interface cbm_req_if;
  import cbm_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] address;
  logic [7:0]  data;

  modport source (output valid, action, address, data, input ready);
  modport sink (input valid, action, address, data, output ready);
endinterface

FILE: rtl/cbm_rsp_if.sv
interface cbm_rsp_if;
  import cbm_pkg::*;

  logic        valid;
  logic        ready;
  logic [18:0] prg_address;
  logic        prg_valid;
  logic [17:0] chr_address;
  logic        mirror_h;
  logic        irq_line;

  modport source (output valid, prg_address, prg_valid, chr_address, mirror_h,
                  irq_line, input ready);
  modport sink (input valid, prg_address, prg_valid, chr_address, mirror_h,
                irq_line, output ready);
endinterface

FILE: rtl/cartridge_bank_mapper_scanline_irq.sv
// Cartridge bank mapper with a scanline interrupt counter. Every request on
// req (a CPU write, a CPU read to translate, a PPU pattern read to translate,
// or a scanline tick) yields exactly one response on rsp, in order. The block
// takes one request per clock: the request is decoded and translated in the
// cycle it is accepted, and the response sits in the output register from the
// next cycle on. The output register is the only stage, so req.ready is high
// whenever that register is empty or is being emptied in the same cycle; a
// stalled response holds back new requests and nothing else.
module cartridge_bank_mapper_scanline_irq
  import cbm_pkg::*;
(
  input logic      clk,
  input logic      rst,
  cbm_req_if.sink  req,
  cbm_rsp_if.source rsp
);

  logic        accept;
  cbm_state_t  state;
  cbm_flags_t  flags_next;
  logic [18:0] prg_address;
  logic        prg_valid;
  logic [17:0] chr_address;

  // Response register and its payload.
  logic        out_valid;
  logic [18:0] out_prg_address;
  logic        out_prg_valid;
  logic [17:0] out_chr_address;
  logic        out_mirror;
  logic        out_irq;

  // A new request may enter whenever the response slot frees up this cycle.
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // Mapper registers: write decode and the scanline counter.
  cbm_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .action     (req.action),
    .address    (req.address),
    .data       (req.data),
    .state      (state),
    .flags_next (flags_next)
  );

  // Address translation uses the state as it stood before this request;
  // only writes and ticks change state, and they produce no translation.
  cbm_xlate u_xlate (
    .action      (req.action),
    .address     (req.address),
    .state       (state),
    .prg_address (prg_address),
    .prg_valid   (prg_valid),
    .chr_address (chr_address)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Mirroring and the interrupt line report the state after this request.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_prg_address <= prg_address;
      out_prg_valid   <= prg_valid;
      out_chr_address <= chr_address;
      out_mirror      <= flags_next.mirror;
      out_irq         <= flags_next.irq;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.prg_address = out_prg_address;
  assign rsp.prg_valid   = out_prg_valid;
  assign rsp.chr_address = out_chr_address;
  assign rsp.mirror_h    = out_mirror;
  assign rsp.irq_line    = out_irq;

endmodule

FILE: rtl/cbm_regs.sv
module cbm_regs
  import cbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  action,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  output cbm_state_t  state,
  output cbm_flags_t  flags_next
);

  logic [7:0]      control, control_next;
  logic [7:0][7:0] banks, banks_next;
  logic [2:0]      slot, slot_next;
  logic            armed, armed_next;
  logic [7:0]      line_count, line_count_next;
  logic            count_en, count_en_next;
  logic            irq, irq_next;
  logic            mirror, mirror_next;
  logic [7:0]      line_dec;

  assign line_dec = line_count - 8'd1;

  always_comb begin
    control_next    = control;
    banks_next      = banks;
    slot_next       = slot;
    armed_next      = armed;
    line_count_next = line_count;
    count_en_next   = count_en;
    irq_next        = irq;
    mirror_next     = mirror;
    if (action == ACT_WRITE) begin
      unique case (address[15:13])
        REGION_CONTROL: begin
          control_next = data;
        end
        REGION_MIRROR: begin
          mirror_next = data[0];
        end
        REGION_SELECT: begin
          slot_next  = data[2:0];
          armed_next = 1'b1;
        end
        REGION_LOAD: begin
          if (armed) begin
            banks_next[slot] = data;
            armed_next       = 1'b0;
          end
        end
        REGION_IRQ: begin
          if (address == ADDR_IRQ_ACK) begin
            irq_next = 1'b0;
          end else if (address == ADDR_IRQ_RELOAD) begin
            line_count_next = data;
            count_en_next   = (data != 8'd0);
          end
        end
        default: begin
        end
      endcase
    end else if (action == ACT_TICK && count_en) begin
      line_count_next = line_dec;
      if (line_dec == 8'd0) begin
        count_en_next = 1'b0;
        irq_next      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control    <= '0;
      banks      <= '0;
      slot       <= '0;
      armed      <= 1'b0;
      line_count <= '0;
      count_en   <= 1'b0;
      irq        <= 1'b0;
      mirror     <= 1'b0;
    end else if (accept) begin
      control    <= control_next;
      banks      <= banks_next;
      slot       <= slot_next;
      armed      <= armed_next;
      line_count <= line_count_next;
      count_en   <= count_en_next;
      irq        <= irq_next;
      mirror     <= mirror_next;
    end
  end

  assign state.control     = control;
  assign state.banks       = banks;
  assign flags_next.mirror = mirror_next;
  assign flags_next.irq    = irq_next;

endmodule

FILE: rtl/cbm_xlate.sv
module cbm_xlate
  import cbm_pkg::*;
(
  input  logic [1:0]  action,
  input  logic [15:0] address,
  input  cbm_state_t  state,
  output logic [18:0] prg_address,
  output logic        prg_valid,
  output logic [17:0] chr_address
);

  logic [7:0] prg_bank;
  logic [7:0] prg_wrapped;
  logic [7:0] chr_bank;
  logic [7:0] chr_wrapped;
  logic [2:0] chr_slot;

  // Program side: the upper 16K is fixed, the lower 16K is either one 16K
  // bank from the control byte or two 8K banks from the bank table.
  always_comb begin
    if (address[14]) begin
      prg_bank = PRG_FIXED_BASE + {7'd0, address[13]};
    end else if (state.control[7]) begin
      prg_bank = {2'b00, state.control[4:0], address[13]};
    end else begin
      prg_bank = state.banks[{2'b10, address[13]}];
    end
  end

  assign prg_wrapped = PRG_WRAP[prg_bank];
  assign prg_valid   = (action == ACT_PRG_READ) && address[15];
  assign prg_address = prg_valid ? {prg_wrapped[5:0], address[12:0]} : '0;

  // Character side: two 2K windows followed by four 1K windows.
  assign chr_slot = address[12:10];

  always_comb begin
    case (chr_slot) inside
      3'd0, 3'd1: chr_bank = {state.banks[0][7:1], chr_slot[0]};
      3'd2, 3'd3: chr_bank = {state.banks[2][7:1], chr_slot[0]};
      3'd4:       chr_bank = state.banks[6];
      3'd5:       chr_bank = state.banks[1];
      3'd6:       chr_bank = state.banks[7];
      default:    chr_bank = state.banks[3];
    endcase
  end

  assign chr_wrapped = CHR_WRAP[chr_bank];
  assign chr_address = (action == ACT_CHR_READ) ? {chr_wrapped, address[9:0]} : '0;

endmodule

FILE: rtl/cbm_checker.sv
module cbm_checker
  import cbm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [18:0] rsp_prg_address,
  input logic        rsp_prg_valid,
  input logic [17:0] rsp_chr_address
);

  // The response register comes out of reset empty.
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

  // A request is never refused while the response slot is free.
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!rsp_valid || rsp_ready) |-> req_ready)
    else $error("request refused with a free response slot");

  // A program address is only reported for a valid program read.
  a_prg_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_prg_valid) |-> (rsp_prg_address == 19'd0))
    else $error("program address without a valid program read");

  // A program read never carries a character address.
  a_chr_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_prg_valid) |-> (rsp_chr_address == 18'd0))
    else $error("character address on a program read");

  // A stalled response keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_prg_address) && $stable(rsp_chr_address)))
    else $error("stalled response changed");

endmodule

bind cartridge_bank_mapper_scanline_irq cbm_checker u_cbm_checker (
  .clk             (clk),
  .rst             (rst),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_prg_address (rsp.prg_address),
  .rsp_prg_valid   (rsp.prg_valid),
  .rsp_chr_address (rsp.chr_address)
);

FILE: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cbm_pkg::*;

  // Cycles with no request or response accepted before the run is declared hung.
  // The longest legal quiet stretch is the forced output hold below.
  localparam int QUIET_LIMIT = 2000;
  localparam int OUTPUT_HOLD_CYCLES = 300;

  // One response as the mapper should produce it.
  typedef struct packed {
    logic [18:0] prg_address;
    logic        prg_valid;
    logic [17:0] chr_address;
    logic        mirror;
    logic        irq;
  } bus_result_t;

  logic clk;
  logic rst;

  cbm_req_if req_if ();
  cbm_rsp_if rsp_if ();

  cartridge_bank_mapper_scanline_irq dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // Mapper state as the testbench tracks it. Reset is applied once, so the
  // declared values stand in for the reset state.
  logic [7:0] ctl_byte = '0;
  logic [7:0] bank_reg [8] = '{default: '0};
  logic [2:0] slot_sel = '0;
  logic       slot_armed = 1'b0;
  logic [7:0] scan_count = '0;
  logic       scan_enabled = 1'b0;
  logic       irq_flag = 1'b0;
  logic       mirror_flag = 1'b0;

  // Responses owed by the block, oldest first.
  bus_result_t bus_results [$];

  int  mismatches = 0;
  int  responses_seen = 0;
  bit  src_idle_on = 1'b0;
  bit  sink_idle_on = 1'b0;
  bit  hold_off_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the tracked state and returns the response it
  // should cause. Flags in the response reflect the state after the request.
  function automatic bus_result_t mapper_step(input logic [1:0] act, input logic [15:0] addr,
                                              input logic [7:0] wdata);
    bus_result_t res;
    int unsigned bank;
    logic [1:0]  win;
    logic [12:0] ppu;
    res = '0;
    case (act)
      ACT_WRITE: begin
        // Writes are decoded by their 8K region; only two addresses inside the
        // top region mean anything, every other top-region write is dropped.
        case (addr[15:13])
          REGION_CONTROL: ctl_byte = wdata;
          REGION_MIRROR: mirror_flag = wdata[0];
          REGION_SELECT: begin
            slot_sel = wdata[2:0];
            slot_armed = 1'b1;
          end
          REGION_LOAD: begin
            if (slot_armed) begin
              bank_reg[slot_sel] = wdata;
              slot_armed = 1'b0;
            end
          end
          REGION_IRQ: begin
            if (addr == ADDR_IRQ_ACK) begin
              irq_flag = 1'b0;
            end else if (addr == ADDR_IRQ_RELOAD) begin
              scan_count = wdata;
              scan_enabled = (wdata != 8'd0);
            end
          end
          default: ;
        endcase
      end
      ACT_PRG_READ: begin
        if (addr[15]) begin
          win = addr[14:13];
          if (win >= 2'd2) begin
            bank = PRG_BANKS_8K - 4 + win;
          end else if (ctl_byte[7]) begin
            bank = {ctl_byte[4:0], 1'b0} + win;
          end else begin
            bank = bank_reg[4 + win];
          end
          bank = bank % PRG_BANKS_8K;
          res.prg_address = 19'((bank << 13) | addr[12:0]);
          res.prg_valid = 1'b1;
        end
      end
      ACT_CHR_READ: begin
        ppu = addr[12:0];
        case (ppu[12:10])
          3'd0, 3'd1: bank = {bank_reg[0][7:1], 1'b0} + ppu[10];
          3'd2, 3'd3: bank = {bank_reg[2][7:1], 1'b0} + ppu[10];
          3'd4: bank = bank_reg[6];
          3'd5: bank = bank_reg[1];
          3'd6: bank = bank_reg[7];
          default: bank = bank_reg[3];
        endcase
        bank = bank % CHR_BANKS_1K;
        res.chr_address = 18'((bank << 10) | ppu[9:0]);
      end
      default: begin
        // A tick only counts while the counter is running; reaching zero stops
        // the counter and raises the interrupt.
        if (scan_enabled) begin
          scan_count = scan_count - 8'd1;
          if (scan_count == 8'd0) begin
            scan_enabled = 1'b0;
            irq_flag = 1'b1;
          end
        end
      end
    endcase
    res.mirror = mirror_flag;
    res.irq = irq_flag;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offers one request, optionally after an idle burst, and waits until the
  // block takes it. The expected response is computed at the accepting edge,
  // so predictions follow the exact order in which the block saw requests.
  task automatic send_request(input logic [1:0] act, input logic [15:0] addr,
                              input logic [7:0] wdata);
    int gap;
    gap = 0;
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
    end
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.action  <= act;
    req_if.address <= addr;
    req_if.data    <= wdata;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    bus_results.push_back(mapper_step(act, addr, wdata));
  endtask

  // Each program window and the first and last character windows straight out
  // of reset, where all bank registers are zero, plus a read just below the
  // program window and a tick while the counter is stopped.
  task automatic test_power_on_map();
    send_request(ACT_PRG_READ, 16'h8000, 8'h00);
    send_request(ACT_PRG_READ, 16'hBFFF, 8'h00);
    send_request(ACT_PRG_READ, 16'hC000, 8'h00);
    send_request(ACT_PRG_READ, 16'hFFFF, 8'hFF);
    send_request(ACT_PRG_READ, 16'h7FFF, 8'h00);
    send_request(ACT_CHR_READ, 16'h0000, 8'h00);
    send_request(ACT_CHR_READ, 16'hFFFF, 8'h00);
    send_request(ACT_TICK, 16'h0000, 8'h00);
  endtask

  // One pass over the write decode: control byte with the 16K mode, a load
  // that arrives without a select, a select with junk in its upper bits and a
  // bank number past the ROM size, mirroring, a one-line counter that fires,
  // acknowledge, a zero reload that keeps the counter stopped, writes that land
  // on nothing, and a last write that lands on the mirroring register.
  task automatic test_register_decode();
    send_request(ACT_WRITE, 16'h6000, 8'h9F);
    send_request(ACT_PRG_READ, 16'h8000, 8'h00);
    send_request(ACT_PRG_READ, 16'hA123, 8'h00);
    send_request(ACT_WRITE, 16'h7FFF, 8'h00);
    send_request(ACT_WRITE, 16'hC000, 8'h55);
    send_request(ACT_WRITE, 16'hA000, 8'hFD);
    send_request(ACT_WRITE, 16'hDFFF, 8'hFF);
    send_request(ACT_PRG_READ, 16'hA000, 8'h00);
    send_request(ACT_WRITE, 16'h8000, 8'h01);
    send_request(ACT_WRITE, 16'hE003, 8'h01);
    send_request(ACT_TICK, 16'hFFFF, 8'hFF);
    send_request(ACT_TICK, 16'h0000, 8'h00);
    send_request(ACT_WRITE, 16'hE002, 8'h00);
    send_request(ACT_WRITE, 16'hE003, 8'h00);
    send_request(ACT_TICK, 16'h0000, 8'h00);
    send_request(ACT_WRITE, 16'hE000, 8'hFF);
    send_request(ACT_WRITE, 16'h5FFF, 8'hFF);
    send_request(ACT_WRITE, 16'hE001, 8'hFF);
    send_request(ACT_WRITE, 16'h9FFF, 8'hFE);
  endtask

  // Random traffic shaped like a game driving the mapper: mostly select/load
  // pairs, control and counter setup, translations and scanline ticks, with
  // some stray writes and loads that have no select in front of them.
  task automatic random_traffic(input int count);
    int sent;
    int kind;
    logic [7:0] wdata;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      wdata = 8'($urandom);
      if (kind < 20) begin
        send_request(ACT_WRITE, {REGION_SELECT, 13'($urandom)}, wdata);
        send_request(ACT_WRITE, {REGION_LOAD, 13'($urandom)}, 8'($urandom));
        sent += 2;
      end else if (kind < 23) begin
        send_request(ACT_WRITE, {REGION_LOAD, 13'($urandom)}, wdata);
        sent++;
      end else if (kind < 31) begin
        send_request(ACT_WRITE, {REGION_CONTROL, 13'($urandom)}, wdata);
        sent++;
      end else if (kind < 35) begin
        send_request(ACT_WRITE, {REGION_MIRROR, 13'($urandom)}, wdata);
        sent++;
      end else if (kind < 42) begin
        // Short reloads so the counter reaches zero often; now and then any value.
        if ($urandom_range(0, 4) != 0) begin
          wdata = 8'($urandom_range(0, 6));
        end
        send_request(ACT_WRITE, ADDR_IRQ_RELOAD, wdata);
        sent++;
      end else if (kind < 46) begin
        send_request(ACT_WRITE, ADDR_IRQ_ACK, wdata);
        sent++;
      end else if (kind < 50) begin
        send_request(ACT_WRITE, 16'($urandom), wdata);
        sent++;
      end else if (kind < 68) begin
        if ($urandom_range(0, 6) != 0) begin
          send_request(ACT_PRG_READ, {1'b1, 15'($urandom)}, wdata);
        end else begin
          send_request(ACT_PRG_READ, 16'($urandom), wdata);
        end
        sent++;
      end else if (kind < 85) begin
        send_request(ACT_CHR_READ, 16'($urandom), wdata);
        sent++;
      end else begin
        send_request(ACT_TICK, 16'($urandom), wdata);
        sent++;
      end
    end
  endtask

  // The sink holds off for a long stretch while the source keeps offering
  // requests back to back, so the output register fills and req.ready drops.
  task automatic test_output_stall();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    hold_off_req = 1'b1;
    random_traffic(60);
  endtask

  task automatic test_random_mapping();
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    random_traffic(1200);
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    random_traffic(500);
  endtask

  // Response side: ready is driven at the falling edge, either following a
  // requested long hold, an idle burst, or simply held high.
  initial begin : drive_rsp_ready
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = OUTPUT_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Each accepted response is compared field by field with the oldest
  // prediction; a response with nothing predicted is an error on its own.
  initial begin : check_responses
    bus_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) begin
        responses_seen++;
        if (bus_results.size() == 0) begin
          report_mismatch($sformatf("response %0d arrived with none outstanding",
                                    responses_seen));
        end else begin
          want = bus_results.pop_front();
          if (rsp_if.prg_address !== want.prg_address) begin
            report_mismatch($sformatf("response %0d prg_address %h, expected %h",
                                      responses_seen, rsp_if.prg_address, want.prg_address));
          end
          if (rsp_if.prg_valid !== want.prg_valid) begin
            report_mismatch($sformatf("response %0d prg_valid %b, expected %b",
                                      responses_seen, rsp_if.prg_valid, want.prg_valid));
          end
          if (rsp_if.chr_address !== want.chr_address) begin
            report_mismatch($sformatf("response %0d chr_address %h, expected %h",
                                      responses_seen, rsp_if.chr_address, want.chr_address));
          end
          if (rsp_if.mirror_h !== want.mirror) begin
            report_mismatch($sformatf("response %0d mirror_h %b, expected %b",
                                      responses_seen, rsp_if.mirror_h, want.mirror));
          end
          if (rsp_if.irq_line !== want.irq) begin
            report_mismatch($sformatf("response %0d irq_line %b, expected %b",
                                      responses_seen, rsp_if.irq_line, want.irq));
          end
        end
      end
    end
  end

  // Hang detection: any cycle that moves a request or a response clears the
  // count, so only a genuinely stuck block can trip it.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] timeout: nothing accepted for %0d cycles", $realtime, QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Main sequence: reset once, run the tests in turn, drain, then decide.
  initial begin : run_tests
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.action = ACT_WRITE;
    req_if.address = '0;
    req_if.data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_power_on_map();
    test_register_decode();
    test_random_mapping();
    test_output_stall();
    test_full_rate();

    @(negedge clk);
    req_if.valid <= 1'b0;

    // The block has a single output register; the wait past the last response is
    // there to catch anything extra.
    while (bus_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && bus_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cbm_pkg.sv
rtl/cbm_req_if.sv
rtl/cbm_rsp_if.sv
rtl/cbm_regs.sv
rtl/cbm_xlate.sv
rtl/cartridge_bank_mapper_scanline_irq.sv
rtl/cbm_checker.sv
dv/testbench.sv
